// File: rtl/tgoc_pkg.sv
// Shared types, codes and constants for the tile grid occupancy and collision core.
package tgoc_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int TILE_SIZE  = 8;
  localparam int FRAC_BITS  = 4;
  localparam int TILE_SHIFT = $clog2(TILE_SIZE) + FRAC_BITS;
  localparam int TS_MASK    = (1 << TILE_SHIFT) - 1;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int COORD_W   = 8;
  localparam int KIND_W    = 8;
  localparam int RECT_W    = 17;
  localparam int SIZE_W    = 16;
  localparam int SPAN_W    = RECT_W + 2;
  localparam int IDX_W     = 2 * CFG_W;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    OP_PLACE   = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_CHECK   = 2'd2,
    OP_COLLIDE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_OOB      = 2'd1,
    STAT_OCCUPIED = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic prep;
    logic chk;
    logic base;
    logic scan;
    logic out_load;
  } tgoc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic collide_op;
    logic span_empty;
    logic scan_last;
    logic hit;
  } tgoc_stat_t;

endpackage

// File: rtl/tgoc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tgoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tgoc_ctrl.sv
// Control state machine: clearing pass, tile access sequence, span scan, result handoff.
module tgoc_ctrl import tgoc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       out_stall,
  input  tgoc_stat_t stat,
  output tgoc_cmd_t  cmd,
  output logic       in_stall,
  output logic       out_valid
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_READ,
    S_CHECK,
    S_BASE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !in_stall_r) begin
          cmd.capture = 1'b1;
          state_nxt   = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = stat.collide_op ? S_BASE : S_READ;
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.chk   = 1'b1;
        state_nxt = S_DONE;
      end
      S_BASE: begin
        cmd.base  = 1'b1;
        state_nxt = stat.span_empty ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last || stat.hit) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
    in_stall_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      in_stall_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= in_stall_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

endmodule

// File: rtl/tgoc_dp.sv
// Datapath: map size registers, index and span arithmetic, scan counters, stores, result words.
module tgoc_dp import tgoc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic [1:0]               in_operation,
  input  logic [COORD_W-1:0]       in_tile_x,
  input  logic [COORD_W-1:0]       in_tile_y,
  input  logic [KIND_W-1:0]        in_tile_kind,
  input  logic signed [RECT_W-1:0] in_rect_left,
  input  logic signed [RECT_W-1:0] in_rect_top,
  input  logic [SIZE_W-1:0]        in_rect_width,
  input  logic [SIZE_W-1:0]        in_rect_height,
  input  tgoc_cmd_t                cmd,
  output tgoc_stat_t               stat,
  output logic                     out_occupied,
  output logic [KIND_W-1:0]        out_kind_out,
  output logic                     out_collided,
  output logic [1:0]               out_status
);

  localparam int GRID   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (GRID > 1) ? $clog2(GRID) : 1;
  localparam int W_RST  = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int H_RST  = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

  function automatic logic [CFG_W-1:0] sat_dim(input logic [CFG_W-1:0] v, input int maxv);
    logic [CFG_W-1:0] res;
    if (v == '0) res = CFG_W'(1);
    else if (int'(v) > maxv) res = CFG_W'(maxv);
    else res = v;
    return res;
  endfunction

  function automatic logic [CFG_W-1:0] clamp_span(input logic signed [SPAN_W-1:0] q,
                                                  input logic [CFG_W-1:0] lim);
    logic signed [SPAN_W-1:0] lim_s;
    logic [CFG_W-1:0]         res;
    lim_s = $signed(SPAN_W'(lim));
    if (q[SPAN_W-1]) res = '0;
    else if (q > lim_s) res = lim;
    else res = q[CFG_W-1:0];
    return res;
  endfunction

  logic [CFG_W-1:0] map_w_r, map_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_w_r <= CFG_W'(W_RST);
      map_h_r <= CFG_W'(H_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_WIDTH:  map_w_r <= sat_dim(cfg_wdata, MAX_WIDTH);
        REG_MAP_HEIGHT: map_h_r <= sat_dim(cfg_wdata, MAX_HEIGHT);
        default: ;
      endcase
    end
  end

  op_t                     op_r;
  logic [COORD_W-1:0]      x_r, y_r;
  logic [KIND_W-1:0]       kind_r;
  logic signed [RECT_W-1:0] l_r, t_r;
  logic [SIZE_W-1:0]       w_r, h_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op_t'(in_operation);
      x_r    <= in_tile_x;
      y_r    <= in_tile_y;
      kind_r <= in_tile_kind;
      l_r    <= in_rect_left;
      t_r    <= in_rect_top;
      w_r    <= in_rect_width;
      h_r    <= in_rect_height;
    end
  end

  logic signed [SPAN_W-1:0] l_ext, t_ext, r_ext, b_ext, rc_ext, bc_ext;
  logic signed [SPAN_W-1:0] q_sx0, q_sy0, q_sx1, q_sy1;

  assign l_ext  = {{(SPAN_W-RECT_W){l_r[RECT_W-1]}}, l_r};
  assign t_ext  = {{(SPAN_W-RECT_W){t_r[RECT_W-1]}}, t_r};
  assign r_ext  = l_ext + $signed({{(SPAN_W-SIZE_W){1'b0}}, w_r});
  assign b_ext  = t_ext + $signed({{(SPAN_W-SIZE_W){1'b0}}, h_r});
  assign rc_ext = r_ext + $signed(SPAN_W'(TS_MASK));
  assign bc_ext = b_ext + $signed(SPAN_W'(TS_MASK));
  assign q_sx0  = l_ext >>> TILE_SHIFT;
  assign q_sy0  = t_ext >>> TILE_SHIFT;
  assign q_sx1  = rc_ext >>> TILE_SHIFT;
  assign q_sy1  = bc_ext >>> TILE_SHIFT;

  logic [CFG_W-1:0] sx0_r, sx1_r, sy0_r, sy1_r;
  logic [CFG_W-1:0] tx_r, ty_r;
  logic [IDX_W-1:0] idx_r, row_base_r;
  logic             oob_r;
  logic [CFG_W-1:0] mul_a;
  logic [IDX_W-1:0] prod;
  logic [IDX_W-1:0] scan_idx;
  logic             tx_end, ty_end;

  assign mul_a    = cmd.base ? sy0_r : {1'b0, y_r};
  assign prod     = mul_a * map_w_r;
  assign scan_idx = row_base_r + IDX_W'(tx_r);
  assign tx_end   = (CFG_W'(tx_r + 1'b1) == sx1_r);
  assign ty_end   = (CFG_W'(ty_r + 1'b1) == sy1_r);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      idx_r <= prod + IDX_W'(x_r);
      oob_r <= ({1'b0, x_r} >= map_w_r) || ({1'b0, y_r} >= map_h_r);
      sx0_r <= clamp_span(q_sx0, map_w_r);
      sy0_r <= clamp_span(q_sy0, map_h_r);
      sx1_r <= clamp_span(q_sx1, map_w_r);
      sy1_r <= clamp_span(q_sy1, map_h_r);
    end
    if (cmd.base) begin
      tx_r       <= sx0_r;
      ty_r       <= sy0_r;
      row_base_r <= prod;
    end else if (cmd.scan) begin
      if (tx_end) begin
        tx_r       <= sx0_r;
        ty_r       <= CFG_W'(ty_r + 1'b1);
        row_base_r <= row_base_r + IDX_W'(map_w_r);
      end else begin
        tx_r <= CFG_W'(tx_r + 1'b1);
      end
    end
  end

  logic [ADDR_W-1:0] clr_cnt_r;
  logic              rd_pend_r, hit_r;
  logic              occ_q;
  logic [KIND_W-1:0] kind_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      rd_pend_r <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      if (cmd.clear) clr_cnt_r <= ADDR_W'(clr_cnt_r + 1'b1);
      rd_pend_r <= cmd.scan;
      if (cmd.base || cmd.chk) hit_r <= 1'b0;
      else if (rd_pend_r && occ_q) hit_r <= 1'b1;
    end
  end

  status_t           chk_status;
  logic              chk_occ;
  logic [KIND_W-1:0] chk_kind;
  logic              occ_we_op, occ_wval, kind_we;

  always_comb begin
    chk_status = STAT_OK;
    chk_occ    = 1'b0;
    chk_kind   = '0;
    occ_we_op  = 1'b0;
    occ_wval   = 1'b0;
    kind_we    = 1'b0;
    if (oob_r) begin
      chk_status = STAT_OOB;
    end else begin
      case (op_r)
        OP_PLACE: begin
          if (occ_q) begin
            chk_status = STAT_OCCUPIED;
          end else begin
            occ_we_op = 1'b1;
            occ_wval  = 1'b1;
            kind_we   = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (!occ_q) chk_status = STAT_EMPTY;
          else occ_we_op = 1'b1;
        end
        OP_CHECK: begin
          chk_occ  = occ_q;
          chk_kind = occ_q ? kind_q : '0;
        end
        default: ;
      endcase
    end
  end

  logic              occ_we;
  logic [ADDR_W-1:0] occ_waddr, occ_raddr, tile_addr;
  logic              occ_wdata;

  assign tile_addr = ADDR_W'(idx_r);
  assign occ_we    = cmd.clear || (cmd.chk && occ_we_op);
  assign occ_waddr = cmd.clear ? clr_cnt_r : tile_addr;
  assign occ_wdata = cmd.clear ? 1'b0 : occ_wval;
  assign occ_raddr = cmd.scan ? ADDR_W'(scan_idx) : tile_addr;

  tgoc_ram #(.WIDTH(1), .DEPTH(GRID)) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (occ_raddr),
    .rdata (occ_q)
  );

  tgoc_ram #(.WIDTH(KIND_W), .DEPTH(GRID)) u_kind_ram (
    .clk   (clk),
    .we    (cmd.chk && kind_we),
    .waddr (tile_addr),
    .wdata (kind_r),
    .raddr (tile_addr),
    .rdata (kind_q)
  );

  logic              res_occ_r;
  logic [KIND_W-1:0] res_kind_r;
  status_t           res_status_r;
  logic              out_occ_r, out_hit_r;
  logic [KIND_W-1:0] out_kind_r;
  status_t           out_status_r;

  always_ff @(posedge clk) begin
    if (cmd.chk) begin
      res_occ_r    <= chk_occ;
      res_kind_r   <= chk_kind;
      res_status_r <= chk_status;
    end else if (cmd.base) begin
      res_occ_r    <= 1'b0;
      res_kind_r   <= '0;
      res_status_r <= STAT_OK;
    end
    if (cmd.out_load) begin
      out_occ_r    <= res_occ_r;
      out_kind_r   <= res_kind_r;
      out_hit_r    <= hit_r;
      out_status_r <= res_status_r;
    end
  end

  assign stat.clr_last   = (clr_cnt_r == ADDR_W'(GRID - 1));
  assign stat.collide_op = (op_r == OP_COLLIDE);
  assign stat.span_empty = !((sx0_r < sx1_r) && (sy0_r < sy1_r));
  assign stat.scan_last  = tx_end && ty_end;
  assign stat.hit        = hit_r || (rd_pend_r && occ_q);

  assign out_occupied = out_occ_r;
  assign out_kind_out = out_kind_r;
  assign out_collided = out_hit_r;
  assign out_status   = out_status_r;

endmodule

// File: rtl/tile_grid_occupancy_collision_core.sv
// Top level of the tile grid occupancy and rectangle collision core.
// Place, remove, check: a word goes through prepare, tile read and check to result load.
// Collide: a word goes through prepare, span base, a scan of the clamped span that ends at
// its last tile or the first hit, and a drain to result load; the single occupancy RAM read
// port reads one tile per cycle during the scan. An empty span goes from span base straight
// to result load. A new word is taken only once the last result is in the output register.
// Reset: map size returns to MAX_WIDTH x MAX_HEIGHT, each capped at 256, and a clearing pass
// over all cells empties the occupancy map while input stays stalled; type entries are not cleared.
module tile_grid_occupancy_collision_core import tgoc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_operation,
  input  logic [COORD_W-1:0]       in_tile_x,
  input  logic [COORD_W-1:0]       in_tile_y,
  input  logic [KIND_W-1:0]        in_tile_kind,
  input  logic signed [RECT_W-1:0] in_rect_left,
  input  logic signed [RECT_W-1:0] in_rect_top,
  input  logic [SIZE_W-1:0]        in_rect_width,
  input  logic [SIZE_W-1:0]        in_rect_height,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_occupied,
  output logic [KIND_W-1:0]        out_kind_out,
  output logic                     out_collided,
  output logic [1:0]               out_status
);

  tgoc_cmd_t  cmd;
  tgoc_stat_t stat;

  tgoc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  tgoc_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_operation   (in_operation),
    .in_tile_x      (in_tile_x),
    .in_tile_y      (in_tile_y),
    .in_tile_kind   (in_tile_kind),
    .in_rect_left   (in_rect_left),
    .in_rect_top    (in_rect_top),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .cmd            (cmd),
    .stat           (stat),
    .out_occupied   (out_occupied),
    .out_kind_out   (out_kind_out),
    .out_collided   (out_collided),
    .out_status     (out_status)
  );

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> in_stall)
    else $error("input word accepted during clearing pass");

  a_accept_starts_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> cmd.prep)
    else $error("accepted word did not enter preparation");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("waiting result word overwritten");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> !stat.span_empty)
    else $error("scan running over an empty span");

endmodule

// File: verif/tile_grid_occupancy_collision_core_tb.sv
// Self-checking testbench: directed table then random place/remove/check/collide traffic.
module tile_grid_occupancy_collision_core_tb;
  import tgoc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_CELLS      = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int TILE_PX        = TILE_SIZE << FRAC_BITS;
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int PHASE_WORDS    = 205;

  typedef struct {
    op_t                      op;
    logic [COORD_W-1:0]       x;
    logic [COORD_W-1:0]       y;
    logic [KIND_W-1:0]        kind;
    logic signed [RECT_W-1:0] left;
    logic signed [RECT_W-1:0] top;
    logic [SIZE_W-1:0]        wid;
    logic [SIZE_W-1:0]        hgt;
  } tile_word_t;

  typedef struct packed {
    logic              occ;
    logic [KIND_W-1:0] kind;
    logic              hit;
    status_t           stat;
  } tile_result_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    tile_word_t           w;
    bit                   typed;
    tile_result_t         res;
  } stim_row_t;

  localparam tile_result_t NO_PIN = '0;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_operation = '0;
  logic [COORD_W-1:0]       in_tile_x = '0;
  logic [COORD_W-1:0]       in_tile_y = '0;
  logic [KIND_W-1:0]        in_tile_kind = '0;
  logic signed [RECT_W-1:0] in_rect_left = '0;
  logic signed [RECT_W-1:0] in_rect_top = '0;
  logic [SIZE_W-1:0]        in_rect_width = '0;
  logic [SIZE_W-1:0]        in_rect_height = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_occupied;
  logic [KIND_W-1:0]        out_kind_out;
  logic                     out_collided;
  logic [1:0]               out_status;

  bit           occ_map [MAP_CELLS];
  logic [7:0]   kind_mem [MAP_CELLS];
  int           cols = DEF_MAX_WIDTH;
  int           rows = DEF_MAX_HEIGHT;
  tile_result_t pending_results [$];
  int           fail_count = 0;
  int           result_no = 0;
  int           quiet_cycles = 0;
  int           src_mode = 0;
  int           sink_mode = 0;
  int           stall_left = 0;
  int           reg_x0, reg_y0, span_x, span_y;
  stim_row_t    plan [$];

  tile_grid_occupancy_collision_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_tile_x(in_tile_x),
    .in_tile_y(in_tile_y),
    .in_tile_kind(in_tile_kind),
    .in_rect_left(in_rect_left),
    .in_rect_top(in_rect_top),
    .in_rect_width(in_rect_width),
    .in_rect_height(in_rect_height),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_occupied(out_occupied),
    .out_kind_out(out_kind_out),
    .out_collided(out_collided),
    .out_status(out_status)
  );

  always #2 clk = ~clk;

  function automatic int map_dim(logic [CFG_W-1:0] v, int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return int'(v);
  endfunction

  function automatic bit rect_hits(longint l, longint t, longint wd, longint ht);
    longint r, b, x0, y0, x1, y1, tx, ty, cx, cy;
    r = l + wd;
    b = t + ht;
    x0 = l >>> TILE_SHIFT;
    y0 = t >>> TILE_SHIFT;
    x1 = (r + TILE_PX - 1) >>> TILE_SHIFT;
    y1 = (b + TILE_PX - 1) >>> TILE_SHIFT;
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > cols) x1 = cols;
    if (y1 > rows) y1 = rows;
    for (ty = y0; ty < y1; ty++) begin
      for (tx = x0; tx < x1; tx++) begin
        cx = tx * TILE_PX;
        cy = ty * TILE_PX;
        if (occ_map[ty * cols + tx] && l < cx + TILE_PX && r > cx && t < cy + TILE_PX && b > cy)
          return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic tile_result_t grid_apply(tile_word_t w);
    tile_result_t r;
    int idx;
    r = '0;
    r.stat = STAT_OK;
    if (w.op == OP_COLLIDE) begin
      r.hit = rect_hits(w.left, w.top, w.wid, w.hgt);
    end else if (w.x >= cols || w.y >= rows) begin
      r.stat = STAT_OOB;
    end else begin
      idx = w.y * cols + w.x;
      case (w.op)
        OP_PLACE: begin
          if (occ_map[idx]) begin
            r.stat = STAT_OCCUPIED;
          end else begin
            occ_map[idx] = 1'b1;
            kind_mem[idx] = w.kind;
          end
        end
        OP_REMOVE: begin
          if (!occ_map[idx]) r.stat = STAT_EMPTY;
          else occ_map[idx] = 1'b0;
        end
        default: begin
          if (occ_map[idx]) begin
            r.occ = 1'b1;
            r.kind = kind_mem[idx];
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic tile_word_t noise_word();
    tile_word_t w;
    w.op = op_t'($urandom_range(0, 3));
    w.x = 8'($urandom);
    w.y = 8'($urandom);
    w.kind = 8'($urandom);
    w.left = 17'($urandom);
    w.top = 17'($urandom);
    w.wid = 16'($urandom);
    w.hgt = 16'($urandom);
    return w;
  endfunction

  function automatic tile_word_t tile_word(op_t op, int x, int y);
    tile_word_t w;
    w = noise_word();
    w.op = op;
    w.x = 8'(x);
    w.y = 8'(y);
    return w;
  endfunction

  function automatic tile_word_t rect_word(int l, int t, int wd, int ht);
    tile_word_t w;
    w = noise_word();
    w.op = OP_COLLIDE;
    w.left = 17'(l);
    w.top = 17'(t);
    w.wid = 16'(wd);
    w.hgt = 16'(ht);
    return w;
  endfunction

  function automatic tile_word_t aim_rect(int tx, int ty);
    int l, t, wd, ht;
    l = tx * TILE_PX;
    t = ty * TILE_PX;
    case ($urandom_range(0, 3))
      0: begin
        wd = TILE_PX * $urandom_range(0, 3);
        ht = TILE_PX * $urandom_range(0, 3);
      end
      1: begin
        l += $urandom_range(0, TILE_PX - 1);
        t += $urandom_range(0, TILE_PX - 1);
        wd = $urandom_range(0, 2);
        ht = $urandom_range(0, 2);
      end
      default: begin
        l += int'($urandom_range(0, 511)) - 256;
        t += int'($urandom_range(0, 511)) - 256;
        wd = $urandom_range(0, 600);
        ht = $urandom_range(0, 600);
      end
    endcase
    return rect_word(l, t, wd, ht);
  endfunction

  function automatic logic [7:0] pick_coord(int base, int span, int lim);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'($urandom_range(0, 255));
    if (r == 1) return 8'($urandom_range(0, lim - 1));
    return 8'(base + int'($urandom_range(0, span - 1)));
  endfunction

  function automatic int idle_odds();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 1;
      2: return 3;
      default: return 7;
    endcase
  endfunction

  function automatic stim_row_t word_row(tile_word_t w);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.w = w;
    r.typed = 1'b0;
    r.res = NO_PIN;
    return r;
  endfunction

  function automatic stim_row_t tile_row(op_t op, int x, int y, int kind);
    stim_row_t r;
    r = word_row(tile_word(op, x, y));
    r.w.kind = 8'(kind);
    return r;
  endfunction

  function automatic stim_row_t rect_row(int l, int t, int wd, int ht);
    return word_row(rect_word(l, t, wd, ht));
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
    stim_row_t r;
    r = word_row(noise_word());
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = 9'(val);
    return r;
  endfunction

  function automatic stim_row_t pin(stim_row_t r, logic occ, int k, logic hit, status_t s);
    r.typed = 1'b1;
    r.res.occ = occ;
    r.res.kind = 8'(k);
    r.res.hit = hit;
    r.res.stat = s;
    return r;
  endfunction

  task automatic flag(string msg);
    $display("%s", msg);
    fail_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAP_WIDTH) cols = map_dim(val, DEF_MAX_WIDTH);
    else rows = map_dim(val, DEF_MAX_HEIGHT);
  endtask

  task automatic set_map(int wv, int hv);
    if ($urandom_range(0, 1)) begin
      write_reg(REG_MAP_WIDTH, 9'(wv));
      write_reg(REG_MAP_HEIGHT, 9'(hv));
    end else begin
      write_reg(REG_MAP_HEIGHT, 9'(hv));
      write_reg(REG_MAP_WIDTH, 9'(wv));
    end
  endtask

  task automatic send_word(tile_word_t w, bit typed, tile_result_t pinned);
    tile_result_t want;
    if (src_mode != 0 && $urandom_range(0, src_mode) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= w.op;
    in_tile_x <= w.x;
    in_tile_y <= w.y;
    in_tile_kind <= w.kind;
    in_rect_left <= w.left;
    in_rect_top <= w.top;
    in_rect_width <= w.wid;
    in_rect_height <= w.hgt;
    do @(posedge clk); while (in_stall !== 1'b0);
    want = grid_apply(w);
    pending_results.push_back(typed ? pinned : want);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (sink_mode != 0 && $urandom_range(0, sink_mode) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        flag($sformatf("result %0d arrived with nothing pending", result_no));
      end else begin
        if (out_occupied !== pending_results[0].occ)
          flag($sformatf("result %0d: occupied %0b, expected %0b", result_no,
                         out_occupied, pending_results[0].occ));
        if (out_kind_out !== pending_results[0].kind)
          flag($sformatf("result %0d: kind_out %0d, expected %0d", result_no,
                         out_kind_out, pending_results[0].kind));
        if (out_collided !== pending_results[0].hit)
          flag($sformatf("result %0d: collided %0b, expected %0b", result_no,
                         out_collided, pending_results[0].hit));
        if (out_status !== pending_results[0].stat)
          flag($sformatf("result %0d: status %0d, expected %0d", result_no,
                         out_status, pending_results[0].stat));
        void'(pending_results.pop_front());
      end
      result_no++;
    end
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    tile_word_t w;
    logic [7:0] tx, ty;
    int n, r, wv, hv, until_shift;

    plan.push_back(pin(tile_row(OP_CHECK, 0, 0, 0), 0, 0, 0, STAT_OK));
    plan.push_back(pin(tile_row(OP_REMOVE, 0, 0, 0), 0, 0, 0, STAT_EMPTY));
    plan.push_back(pin(tile_row(OP_PLACE, 0, 0, 255), 0, 0, 0, STAT_OK));
    plan.push_back(pin(tile_row(OP_PLACE, 0, 0, 0), 0, 0, 0, STAT_OCCUPIED));
    plan.push_back(pin(tile_row(OP_CHECK, 0, 0, 0), 1, 255, 0, STAT_OK));
    plan.push_back(pin(tile_row(OP_PLACE, 255, 255, 8'h5A), 0, 0, 0, STAT_OK));
    plan.push_back(pin(tile_row(OP_CHECK, 255, 255, 0), 1, 8'h5A, 0, STAT_OK));
    plan.push_back(pin(rect_row(-65536, -65536, 65535, 65535), 0, 0, 0, STAT_OK));
    plan.push_back(pin(rect_row(0, 0, TILE_PX, TILE_PX), 0, 0, 1, STAT_OK));
    plan.push_back(rect_row(TILE_PX, 0, TILE_PX, TILE_PX));
    plan.push_back(pin(rect_row(65535, 65535, 65535, 65535), 0, 0, 0, STAT_OK));
    plan.push_back(rect_row(1, 1, 0, 0));
    plan.push_back(rect_row(255 * TILE_PX + 1, 255 * TILE_PX + 1, 0, 0));
    plan.push_back(pin(tile_row(OP_REMOVE, 0, 0, 0), 0, 0, 0, STAT_OK));
    plan.push_back(pin(tile_row(OP_REMOVE, 0, 0, 0), 0, 0, 0, STAT_EMPTY));
    plan.push_back(pin(tile_row(OP_CHECK, 0, 0, 0), 0, 0, 0, STAT_OK));
    plan.push_back(tile_row(OP_REMOVE, 255, 255, 0));
    plan.push_back(pin(rect_row(-16, -16, 65535, 65535), 0, 0, 0, STAT_OK));
    plan.push_back(cfg_row(REG_MAP_WIDTH, 0));
    plan.push_back(cfg_row(REG_MAP_HEIGHT, 511));
    plan.push_back(pin(tile_row(OP_PLACE, 1, 0, 3), 0, 0, 0, STAT_OOB));
    plan.push_back(pin(tile_row(OP_CHECK, 200, 200, 0), 0, 0, 0, STAT_OOB));
    plan.push_back(pin(tile_row(OP_REMOVE, 255, 0, 0), 0, 0, 0, STAT_OOB));
    plan.push_back(pin(tile_row(OP_PLACE, 0, 5, 7), 0, 0, 0, STAT_OK));
    plan.push_back(cfg_row(REG_MAP_WIDTH, 256));
    plan.push_back(tile_row(OP_CHECK, 5, 0, 0));
    plan.push_back(tile_row(OP_REMOVE, 5, 0, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    src_mode = 3;
    sink_mode = 3;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else send_word(plan[i].w, plan[i].typed, plan[i].res);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin wv = 256; hv = 256; end
        1: begin wv = 0; hv = 1; end
        2: begin wv = $urandom_range(1, 40); hv = $urandom_range(1, 40); end
        3: begin wv = 511; hv = 3; end
        4: begin wv = 2; hv = 300; end
        5: begin wv = $urandom_range(0, 511); hv = $urandom_range(0, 511); end
        6: begin wv = $urandom_range(1, 24); hv = $urandom_range(1, 24); end
        default: begin wv = 256; hv = 256; end
      endcase
      set_map(wv, hv);
      span_x = cols < 8 ? cols : 8;
      span_y = rows < 8 ? rows : 8;
      reg_x0 = $urandom_range(0, cols - span_x);
      reg_y0 = $urandom_range(0, rows - span_y);
      n = 0;
      until_shift = 0;
      while (n < PHASE_WORDS) begin
        if (until_shift <= 0) begin
          src_mode = (ph == 7) ? 0 : idle_odds();
          sink_mode = (ph == 7) ? 0 : idle_odds();
          until_shift = 50;
        end
        if (ph != 7 && $urandom_range(0, 99) == 0) drain();
        tx = pick_coord(reg_x0, span_x, cols);
        ty = pick_coord(reg_y0, span_y, rows);
        if ($urandom_range(0, 4) == 0) begin
          send_word(tile_word(OP_PLACE, tx, ty), 1'b0, NO_PIN);
          send_word(tile_word(OP_CHECK, tx, ty), 1'b0, NO_PIN);
          send_word(aim_rect(tx, ty), 1'b0, NO_PIN);
          n += 3;
          if ($urandom_range(0, 1)) begin
            send_word(tile_word(OP_REMOVE, tx, ty), 1'b0, NO_PIN);
            send_word(tile_word(OP_CHECK, tx, ty), 1'b0, NO_PIN);
            n += 2;
          end
        end else begin
          r = $urandom_range(0, 19);
          if (r < 6) w = tile_word(OP_PLACE, tx, ty);
          else if (r < 10) w = tile_word(OP_REMOVE, tx, ty);
          else if (r < 15) w = tile_word(OP_CHECK, tx, ty);
          else if ($urandom_range(0, 79) == 0) begin
            w = noise_word();
            w.op = OP_COLLIDE;
          end else w = aim_rect(tx, ty);
          send_word(w, 1'b0, NO_PIN);
          n++;
        end
        until_shift -= 1;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
